// File: rtl/rc4_stream_cipher_top_defines.svh
// Assertion macros shared by the RC4 stream cipher RTL.
`ifndef RC4_STREAM_CIPHER_TOP_DEFINES_SVH
`define RC4_STREAM_CIPHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is low.
`define RC4SC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rc4sc check failed");
// Clocked check that also holds during reset.
`define RC4SC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rc4sc check failed");
`else
`define RC4SC_ASSERT(lbl, clk, rst_n, prop)
`define RC4SC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/rc4sc_pkg.sv
// Types and constants shared by the RC4 stream cipher modules.
`default_nettype none

package rc4sc_pkg;

    localparam int unsigned PERM_W     = 8;
    localparam int unsigned PERM_SIZE  = 256;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned KEY_LEN_W  = 6;
    localparam int unsigned KEY_WORDS  = 4;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_W0  = 3'd1;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd31;
    localparam logic [PERM_W-1:0]    PERM_LAST     = 8'd255;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_RD_X,
        S_RD_J,
        S_SWAP
    } t_state;

    typedef struct packed {
        logic              en;
        logic [PERM_W-1:0] addr;
        logic [PERM_W-1:0] data;
    } t_mem_wr;

endpackage

`default_nettype wire

// File: rtl/rc4sc_perm_mem.sv
// 256 x 8 permutation memory: one write port, one registered read port.
`default_nettype none

module rc4sc_perm_mem (
    input  wire logic                        i_clk,
    input  wire rc4sc_pkg::t_mem_wr          i_wr,
    input  wire logic                        i_rd_en,
    input  wire logic [rc4sc_pkg::PERM_W-1:0] i_rd_addr,
    output logic      [rc4sc_pkg::PERM_W-1:0] o_rd_data
);
    import rc4sc_pkg::*;

    logic [PERM_W-1:0] r_mem [PERM_SIZE];
    logic [PERM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read-first: a same-cycle write is not seen
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/rc4sc_key_regs.sv
// Key registers, effective key length and the key byte index counter.
`default_nettype none

module rc4sc_key_regs #(
    parameter int unsigned MAX_KEY_BYTES = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr,
    input  wire logic [rc4sc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rc4sc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_kidx_clr,
    input  wire logic                            i_kidx_adv,
    output logic      [rc4sc_pkg::PERM_W-1:0]     o_key_byte
);
    import rc4sc_pkg::*;

    // bytes the key words can reach, limited by the parameter
    localparam int unsigned KEY_STORE = (MAX_KEY_BYTES < KEY_WORDS * 8) ?
                                        MAX_KEY_BYTES : KEY_WORDS * 8;
    localparam int unsigned IDX_W     = (KEY_STORE > 1) ? $clog2(KEY_STORE) : 1;
    localparam int unsigned LEN_CAP   = (MAX_KEY_BYTES < 63) ? MAX_KEY_BYTES : 63;

    logic [KEY_LEN_W-1:0] r_key_len;
    logic [PERM_W-1:0]    r_key [KEY_STORE];
    logic [KEY_LEN_W-1:0] r_kidx;
    logic [KEY_LEN_W-1:0] n_kidx;
    logic [KEY_LEN_W-1:0] len_nz;
    logic [KEY_LEN_W-1:0] len_eff;
    logic [KEY_LEN_W-1:0] len_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= KEY_LEN_RESET;
        end else if (i_cfg_wr && (i_cfg_index == CFG_KEY_LEN)) begin
            r_key_len <= i_cfg_data[KEY_LEN_W-1:0];
        end
    end

    for (genvar p = 0; p < KEY_STORE; p++) begin : g_key
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_key[p] <= '0;
            end else if (i_cfg_wr &&
                         (i_cfg_index == CFG_KEY_W0 + CFG_IDX_W'(p / 8))) begin
                r_key[p] <= i_cfg_data[8 * (p % 8) +: 8];
            end
        end
    end

    // zero length acts as one, long lengths clamp to the parameter
    always_comb begin
        len_nz  = (r_key_len == '0) ? KEY_LEN_W'(1) : r_key_len;
        len_eff = (len_nz > KEY_LEN_W'(LEN_CAP)) ? KEY_LEN_W'(LEN_CAP) : len_nz;
        len_m1  = len_eff - KEY_LEN_W'(1);
    end

    always_comb begin
        n_kidx = r_kidx;
        if (i_kidx_clr) begin
            n_kidx = '0;
        end else if (i_kidx_adv) begin
            n_kidx = (r_kidx >= len_m1) ? '0 : r_kidx + KEY_LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kidx <= '0;
        end else begin
            r_kidx <= n_kidx;
        end
    end

    assign o_key_byte = ({1'b0, r_kidx} < (KEY_LEN_W + 1)'(KEY_STORE)) ?
                        r_key[r_kidx[IDX_W-1:0]] : '0;

endmodule

`default_nettype wire

// File: rtl/rc4_stream_cipher_top.sv
// RC4 stream cipher: key schedule and keystream XOR over a byte stream.
//
// Channel   Dir  Handshake                  Payload
// s_axis    in   tvalid/tready              tdata = data_in, tuser = first_of_message
// m_axis    out  tvalid/tready              tdata = data_out
// cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data (64 bits)
//
// A keyed byte steps through S_RD_X (read S[i]), S_RD_J (read S[j]) and S_SWAP
// (write S[i] and read S[S[i]+S[j]]); S[j] is written back later, when the write port is idle.
// The single write port of the permutation memory sets this pace.
// A message start (or any byte before the first start) adds a key schedule:
// S_INIT fills S with the identity, then 256 swaps run through the same states.
// Reset clears control state only; the permutation memory is rebuilt by the
// key schedule. A stalled output holds the block in the swap cycle.
`default_nettype none

`include "rc4_stream_cipher_top_defines.svh"

module rc4_stream_cipher_top #(
    parameter int unsigned MAX_KEY_BYTES = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input stream
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [7:0]                      i_s_axis_tdata,   // [7:0] data_in
    input  wire logic [0:0]                      i_s_axis_tuser,   // [0] first_of_message
    // output stream
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic      [7:0]                      o_m_axis_tdata,   // [7:0] data_out
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rc4sc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rc4sc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rc4sc_pkg::*;

    t_state r_state, n_state;

    logic [PERM_W-1:0] r_x, n_x;        // i during bytes, k during key schedule
    logic [PERM_W-1:0] r_j, n_j;
    logic [PERM_W-1:0] r_sx, n_sx;      // S[x] before the swap
    logic              r_fx, n_fx;      // S[x] read collided with pending write
    logic [PERM_W-1:0] r_fxd, n_fxd;
    logic              r_pend, n_pend;  // deferred write of S[j]
    logic [PERM_W-1:0] r_pa, n_pa;
    logic [PERM_W-1:0] r_pd, n_pd;
    logic              r_ksa, n_ksa;    // key schedule swaps in progress
    logic              r_keyed, n_keyed;
    logic [7:0]        r_din, n_din;    // byte in work
    logic [7:0]        r_xdin, n_xdin;  // byte waiting for its keystream
    logic              r_ks_pend, n_ks_pend;
    logic              r_ks_fwd, n_ks_fwd;
    logic [PERM_W-1:0] r_ks_fd, n_ks_fd;
    logic              r_ovalid, n_ovalid;
    logic [7:0]        r_odata, n_odata;

    t_mem_wr           mem_wr;
    logic              mem_rd_en;
    logic [PERM_W-1:0] mem_rd_addr;
    logic [PERM_W-1:0] mem_rd_data;
    logic [PERM_W-1:0] key_byte;
    logic              kidx_clr;
    logic              kidx_adv;
    logic              s_ready;
    logic              s_accept;
    logic              out_free;
    logic [PERM_W-1:0] addr_x;
    logic [PERM_W-1:0] sx;
    logic [PERM_W-1:0] kadd;
    logic [PERM_W-1:0] ks_addr;

    rc4sc_key_regs #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_key_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_kidx_clr  (kidx_clr),
        .i_kidx_adv  (kidx_adv),
        .o_key_byte  (key_byte)
    );

    rc4sc_perm_mem u_perm_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_axis_tvalid && s_ready;
    // output register is free for a keystream byte landing next cycle
    assign out_free    = !r_ovalid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= 1'b0;
            r_ksa     <= 1'b0;
            r_keyed   <= 1'b0;
            r_ks_pend <= 1'b0;
            r_ovalid  <= 1'b0;
            r_x       <= '0;
            r_j       <= '0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_ksa     <= n_ksa;
            r_keyed   <= n_keyed;
            r_ks_pend <= n_ks_pend;
            r_ovalid  <= n_ovalid;
            r_x       <= n_x;
            r_j       <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx     <= n_sx;
        r_fx     <= n_fx;
        r_fxd    <= n_fxd;
        r_pa     <= n_pa;
        r_pd     <= n_pd;
        r_din    <= n_din;
        r_xdin   <= n_xdin;
        r_ks_fwd <= n_ks_fwd;
        r_ks_fd  <= n_ks_fd;
        r_odata  <= n_odata;
    end

    always_comb begin
        n_state   = r_state;
        n_x       = r_x;
        n_j       = r_j;
        n_sx      = r_sx;
        n_fx      = r_fx;
        n_fxd     = r_fxd;
        n_pend    = r_pend;
        n_pa      = r_pa;
        n_pd      = r_pd;
        n_ksa     = r_ksa;
        n_keyed   = r_keyed;
        n_din     = r_din;
        n_xdin    = r_xdin;
        n_ks_pend = 1'b0;
        n_ks_fwd  = r_ks_fwd;
        n_ks_fd   = r_ks_fd;
        n_ovalid  = r_ovalid && !i_m_axis_tready;
        n_odata   = r_odata;
        mem_wr    = '0;
        mem_rd_en = 1'b0;
        mem_rd_addr = r_x;
        kidx_clr  = 1'b0;
        kidx_adv  = 1'b0;
        s_ready   = 1'b0;
        addr_x    = r_ksa ? r_x : r_x + PERM_W'(1);
        sx        = r_fx ? r_fxd : mem_rd_data;
        kadd      = r_ksa ? key_byte : '0;
        ks_addr   = r_sx + mem_rd_data;

        // keystream byte of the previous swap arrives now
        if (r_ks_pend) begin
            n_ovalid = 1'b1;
            n_odata  = r_xdin ^ (r_ks_fwd ? r_ks_fd : mem_rd_data);
        end

        // deferred S[j] write goes out whenever the write port is idle
        if (r_pend && (r_state == S_IDLE || r_state == S_RD_X || r_state == S_RD_J)) begin
            mem_wr = '{en: 1'b1, addr: r_pa, data: r_pd};
            n_pend = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_INIT: begin
                mem_wr = '{en: 1'b1, addr: r_x, data: r_x};
                n_x    = r_x + PERM_W'(1);
                if (r_x == PERM_LAST) begin
                    n_ksa   = 1'b1;
                    n_j     = '0;
                    n_state = S_RD_X;
                end
            end
            S_RD_X: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = addr_x;
                n_fx        = r_pend && (r_pa == addr_x);
                n_fxd       = r_pd;
                n_x         = addr_x;
                n_state     = S_RD_J;
            end
            S_RD_J: begin
                n_sx        = sx;
                n_j         = r_j + sx + kadd;
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_j + sx + kadd;
                n_state     = S_SWAP;
            end
            S_SWAP: begin
                if (r_ksa) begin
                    mem_wr   = '{en: 1'b1, addr: r_x, data: mem_rd_data};
                    n_pend   = 1'b1;
                    n_pa     = r_j;
                    n_pd     = r_sx;
                    kidx_adv = 1'b1;
                    n_state  = S_RD_X;
                    if (r_x == PERM_LAST) begin
                        n_ksa   = 1'b0;
                        n_keyed = 1'b1;
                        n_x     = '0;
                        n_j     = '0;
                    end else begin
                        n_x = r_x + PERM_W'(1);
                    end
                end else if (out_free) begin
                    mem_wr      = '{en: 1'b1, addr: r_x, data: mem_rd_data};
                    n_pend      = 1'b1;
                    n_pa        = r_j;
                    n_pd        = r_sx;
                    // keystream read, forwarding the two swapped entries
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ks_addr;
                    n_ks_fwd    = (ks_addr == r_x) || (ks_addr == r_j);
                    n_ks_fd     = (ks_addr == r_x) ? mem_rd_data : r_sx;
                    n_ks_pend   = 1'b1;
                    n_xdin      = r_din;
                    s_ready     = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // new byte: key schedule first on a message start or when never keyed
        if (s_accept) begin
            n_din = i_s_axis_tdata;
            if (i_s_axis_tuser[0] || !r_keyed) begin
                n_state  = S_INIT;
                n_x      = '0;
                n_pend   = 1'b0;
                kidx_clr = 1'b1;
            end else begin
                n_state = S_RD_X;
            end
        end
    end

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // a keystream byte never lands on an output still waiting for transfer
    `RC4SC_ASSERT(a_out_free, i_clk, i_rst_n, r_ks_pend |-> !r_ovalid)
    // the deferred write has always drained before the next swap
    `RC4SC_ASSERT(a_swap_no_pend, i_clk, i_rst_n, (r_state == S_SWAP) |-> !r_pend)
    // the identity fill never races a deferred write
    `RC4SC_ASSERT(a_init_no_pend, i_clk, i_rst_n, (r_state == S_INIT) |-> !r_pend)
    // a byte taken in the swap cycle still delivers the finished result
    `RC4SC_ASSERT(a_swap_result, i_clk, i_rst_n,
        (s_accept && r_state == S_SWAP) |=> r_ks_pend)
    // an output stall parks the block in the swap cycle
    `RC4SC_ASSERT(a_stall_hold, i_clk, i_rst_n,
        (r_state == S_SWAP && !r_ksa && !out_free) |=> (r_state == S_SWAP))

endmodule

`default_nettype wire
